// ----- sv/rrbs_pkg.sv -----
`default_nettype none
package rrbs_pkg;

	localparam int OFF_BITS     = 31;
	localparam int ROW_BITS     = 16;
	localparam int LIMIT_BITS   = 63;
	localparam int GROWTH_BITS  = 2 * OFF_BITS;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS    = QPTR_BITS + 1;
	localparam int CFG_IDX_BITS = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SQUARE   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STRICT   = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ABSOLUTE = 2'd3;

	typedef logic [1:0] err_t;

	localparam err_t ERR_NONE       = 2'd0;
	localparam err_t ERR_EMPTY      = 2'd1;
	localparam err_t ERR_FIRST_BIG  = 2'd2;
	localparam err_t ERR_DECREASING = 2'd3;

	typedef struct packed {
		logic [LIMIT_BITS-1:0] limit;
		logic                  square;
		logic                  strict;
		logic                  absolute;
	} rrbs_cfg_t;

	// one closed batch or error, as handed from front to back
	typedef struct packed {
		err_t                err;
		logic [ROW_BITS-1:0] row;
		logic [ROW_BITS-1:0] base_row;
		logic [OFF_BITS-1:0] end_off;
		logic [OFF_BITS-1:0] start_off;
		logic                done;
		logic                last_res;
	} rrbs_rec_t;

	// up to two records per decision, rec0 first
	typedef struct packed {
		logic      vld0;
		logic      vld1;
		rrbs_rec_t rec0;
		rrbs_rec_t rec1;
	} rrbs_push_t;

endpackage
`default_nettype wire

// ----- sv/rrbs_front.sv -----
`default_nettype none
module rrbs_front import rrbs_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rrbs_cfg_t           cfg,
	input  wire logic                push,
	input  wire logic [OFF_BITS-1:0] row_offset,
	input  wire logic                last_offset,
	output logic                     full,
	input  wire logic                q_space,
	output rrbs_push_t               q_push
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CALC   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	logic [1:0] st_q;

	// captured item
	logic [OFF_BITS-1:0] s_q;
	logic                last_q;

	// list state
	logic [OFF_BITS-1:0] bso_q;
	logic [ROW_BITS-1:0] bsr_q;
	logic [OFF_BITS-1:0] prev_q;
	logic [ROW_BITS-1:0] row_q;
	logic                hold_q;
	logic                start_q;
	logic                first_q;

	// growth values from the calc cycle
	logic [GROWTH_BITS-1:0] gn_q;
	logic [GROWTH_BITS-1:0] gp_q;

	logic [OFF_BITS-1:0]    dn, dp;
	logic [GROWTH_BITS-1:0] sq_n, sq_p;

	logic go, accept;

	logic [OFF_BITS-1:0] nxt_bso, nxt_prev;
	logic [ROW_BITS-1:0] nxt_bsr, nxt_row;
	logic                nxt_hold, nxt_start, nxt_first;

	logic                gn_gt, gn_eq, gp_ge, decr, n_one;
	logic [ROW_BITS-1:0] n_rows, row_m1;
	rrbs_rec_t           err_rec;

	assign go     = (st_q == ST_DECIDE) && q_space;
	assign full   = !((st_q == ST_IDLE) || go);
	assign accept = push && !full;

	// offset differences and their growth
	assign dn   = s_q - (first_q ? {OFF_BITS{1'b0}} : bso_q);
	assign dp   = s_q - prev_q;
	assign sq_n = GROWTH_BITS'(dn) * GROWTH_BITS'(dn);
	assign sq_p = GROWTH_BITS'(dp) * GROWTH_BITS'(dp);

	// compares used by the decision
	assign gn_gt  = {1'b0, gn_q} > cfg.limit;
	assign gn_eq  = {1'b0, gn_q} == cfg.limit;
	assign gp_ge  = {1'b0, gp_q} >= cfg.limit;
	assign decr   = s_q < prev_q;
	assign n_rows = row_q - bsr_q;
	assign n_one  = n_rows == ROW_BITS'(1);
	assign row_m1 = row_q - ROW_BITS'(1);

	// decision: next list state and records to queue
	always_comb begin
		nxt_bso   = bso_q;
		nxt_bsr   = bsr_q;
		nxt_prev  = prev_q;
		nxt_row   = row_q;
		nxt_hold  = hold_q;
		nxt_start = start_q;
		nxt_first = first_q;
		q_push    = '0;

		err_rec          = '0;
		err_rec.row      = row_q;
		err_rec.done     = last_q;
		err_rec.last_res = 1'b1;

		priority if (hold_q) begin
			// swallow items until the list ends
		end else if (start_q) begin
			priority if (gn_gt) begin
				q_push.vld0     = 1'b1;
				q_push.rec0     = err_rec;
				q_push.rec0.err = ERR_FIRST_BIG;
				nxt_hold        = 1'b1;
			end else if (gn_eq || last_q) begin
				q_push.vld0     = 1'b1;
				q_push.rec0     = err_rec;
				q_push.rec0.err = ERR_EMPTY;
				nxt_hold        = 1'b1;
			end else begin
				nxt_start = 1'b0;
				nxt_first = 1'b1;
				nxt_bso   = s_q;
				nxt_bsr   = '0;
				nxt_prev  = s_q;
				nxt_row   = ROW_BITS'(1);
			end
		end else if (decr) begin
			q_push.vld0     = 1'b1;
			q_push.rec0     = err_rec;
			q_push.rec0.err = ERR_DECREASING;
			nxt_hold        = 1'b1;
		end else begin
			if (gn_gt && !n_one) begin
				// close at the previous row, maybe the current row too
				q_push.vld0           = 1'b1;
				q_push.rec0.err       = ERR_NONE;
				q_push.rec0.row       = row_m1;
				q_push.rec0.base_row  = bsr_q;
				q_push.rec0.end_off   = prev_q;
				q_push.rec0.start_off = bso_q;
				nxt_bso               = prev_q;
				nxt_bsr               = row_m1;
				nxt_first             = 1'b0;
				if (gp_ge || last_q) begin
					q_push.vld1           = 1'b1;
					q_push.rec1.err       = ERR_NONE;
					q_push.rec1.row       = row_q;
					q_push.rec1.base_row  = row_m1;
					q_push.rec1.end_off   = s_q;
					q_push.rec1.start_off = prev_q;
					q_push.rec1.done      = last_q;
					q_push.rec1.last_res  = 1'b1;
					nxt_bso               = s_q;
					nxt_bsr               = row_q;
				end else begin
					q_push.rec0.done     = last_q;
					q_push.rec0.last_res = 1'b1;
				end
			end else if (gn_eq || last_q || gn_gt) begin
				q_push.vld0           = 1'b1;
				q_push.rec0.err       = ERR_NONE;
				q_push.rec0.row       = row_q;
				q_push.rec0.base_row  = bsr_q;
				q_push.rec0.end_off   = s_q;
				q_push.rec0.start_off = bso_q;
				q_push.rec0.done      = last_q;
				q_push.rec0.last_res  = 1'b1;
				nxt_bso               = s_q;
				nxt_bsr               = row_q;
				nxt_first             = 1'b0;
			end
			nxt_prev = s_q;
			nxt_row  = row_q + ROW_BITS'(1);
		end

		// list end returns all list state to reset values
		if (last_q) begin
			nxt_bso   = '0;
			nxt_bsr   = '0;
			nxt_prev  = '0;
			nxt_row   = '0;
			nxt_hold  = 1'b0;
			nxt_start = 1'b1;
			nxt_first = 1'b1;
		end

		if (!go) begin
			q_push.vld0 = 1'b0;
			q_push.vld1 = 1'b0;
		end
	end

	// control sequence: capture, calc, decide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) st_q <= ST_CALC;
				end
				ST_CALC: begin
					st_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (go) st_q <= accept ? ST_CALC : ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// list state update on a decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bso_q   <= '0;
			bsr_q   <= '0;
			prev_q  <= '0;
			row_q   <= '0;
			hold_q  <= 1'b0;
			start_q <= 1'b1;
			first_q <= 1'b1;
		end else if (go) begin
			bso_q   <= nxt_bso;
			bsr_q   <= nxt_bsr;
			prev_q  <= nxt_prev;
			row_q   <= nxt_row;
			hold_q  <= nxt_hold;
			start_q <= nxt_start;
			first_q <= nxt_first;
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (accept) begin
			s_q    <= row_offset;
			last_q <= last_offset;
		end
	end

	// growth registers
	always_ff @(posedge clk) begin
		if (st_q == ST_CALC) begin
			gn_q <= cfg.square ? sq_n : GROWTH_BITS'(dn);
			gp_q <= cfg.square ? sq_p : GROWTH_BITS'(dp);
		end
	end

endmodule
`default_nettype wire

// ----- sv/rrbs_queue.sv -----
`default_nettype none
module rrbs_queue import rrbs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire rrbs_push_t q_push,
	output logic            q_space,
	output logic            head_vld,
	output rrbs_rec_t       head,
	input  wire logic       head_pop
);

	rrbs_rec_t mem_q [QUEUE_DEPTH];

	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic [QCNT_BITS-1:0] n_wr;
	logic                 do_pop;

	assign q_space  = cnt_q <= QCNT_BITS'(QUEUE_DEPTH - 2);
	assign head_vld = cnt_q != '0;
	assign head     = mem_q[rd_q];
	assign do_pop   = head_pop && head_vld;
	assign n_wr     = QCNT_BITS'(q_push.vld0) + QCNT_BITS'(q_push.vld1);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_wr[QPTR_BITS-1:0];
			rd_q  <= rd_q + QPTR_BITS'(do_pop);
			cnt_q <= cnt_q + n_wr - QCNT_BITS'(do_pop);
		end
	end

	// up to two writes per cycle
	always_ff @(posedge clk) begin
		if (q_push.vld0) mem_q[wr_q] <= q_push.rec0;
		if (q_push.vld1) mem_q[wr_q + QPTR_BITS'(1)] <= q_push.rec1;
	end

endmodule
`default_nettype wire

// ----- sv/rrbs_back.sv -----
`default_nettype none
module rrbs_back import rrbs_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rrbs_cfg_t            cfg,
	input  wire logic                 head_vld,
	input  wire rrbs_rec_t            head,
	output logic                      head_pop,
	output logic                      empty,
	input  wire logic                 pop,
	output logic [ROW_BITS-1:0]       split_index,
	output logic [OFF_BITS-1:0]       element_count,
	output logic                      size_ok,
	output err_t                      error_code,
	output logic                      list_done,
	output logic                      last_result
);

	logic                out_vld_q;
	logic                load;
	logic [OFF_BITS-1:0] cnt;
	logic [ROW_BITS-1:0] idx;
	logic                ok;
	logic                is_err;

	assign empty    = !out_vld_q;
	assign load     = head_vld && (!out_vld_q || pop);
	assign head_pop = load;

	// result fields of one record
	assign is_err = head.err != ERR_NONE;
	assign cnt    = is_err ? {OFF_BITS{1'b0}} : head.end_off - head.start_off;
	assign idx    = (is_err || cfg.absolute) ? head.row : head.row - head.base_row;
	assign ok     = !is_err && (cnt != '0)
	                && (!cfg.strict || ({{(LIMIT_BITS-OFF_BITS){1'b0}}, cnt} <= cfg.limit));

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			split_index   <= idx;
			element_count <= cnt;
			size_ok       <= ok;
			error_code    <= head.err;
			list_done     <= head.done;
			last_result   <= head.last_res;
		end
	end

endmodule
`default_nettype wire

// ----- sv/ragged_row_batch_splitter.sv -----
// a result passes input capture, growth registers, queue and output register
// the front takes a new offset no earlier than the decide step for the last one
//   (calc registers the growth; decide compares it and updates the batch state)
// an offset closing two batches delivers its two results in order, the first before the second
// reset: arst_n clears list state, queue, output valid and all configuration registers
`default_nettype none
module ragged_row_batch_splitter import rrbs_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic [OFF_BITS-1:0]     row_offset,
	input  wire logic                    last_offset,
	output logic                         empty,
	input  wire logic                    pop,
	output logic [ROW_BITS-1:0]          split_index,
	output logic [OFF_BITS-1:0]          element_count,
	output logic                         size_ok,
	output logic [1:0]                   error_code,
	output logic                         list_done,
	output logic                         last_result,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [LIMIT_BITS-1:0]   cfg_data
);

	rrbs_cfg_t  cfg_q;
	rrbs_push_t q_push;
	rrbs_rec_t  head;
	logic       q_space, head_vld, head_pop;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LIMIT:    cfg_q.limit    <= cfg_data;
				CFG_SQUARE:   cfg_q.square   <= cfg_data[0];
				CFG_STRICT:   cfg_q.strict   <= cfg_data[0];
				CFG_ABSOLUTE: cfg_q.absolute <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	rrbs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.row_offset  (row_offset),
		.last_offset (last_offset),
		.full        (full),
		.q_space     (q_space),
		.q_push      (q_push)
	);

	rrbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_push   (q_push),
		.q_space  (q_space),
		.head_vld (head_vld),
		.head     (head),
		.head_pop (head_pop)
	);

	rrbs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head_vld      (head_vld),
		.head          (head),
		.head_pop      (head_pop),
		.empty         (empty),
		.pop           (pop),
		.split_index   (split_index),
		.element_count (element_count),
		.size_ok       (size_ok),
		.error_code    (error_code),
		.list_done     (list_done),
		.last_result   (last_result)
	);

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
module tb;
	import rrbs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RUN_LIMIT = 2_000_000;
	localparam logic [63:0] OFF_MAX = 64'h7FFF_FFFF;

	// one batch or error as it leaves the block
	typedef struct packed {
		logic [ROW_BITS-1:0] split_index;
		logic [OFF_BITS-1:0] element_count;
		logic                size_ok;
		err_t                error_code;
		logic                list_done;
		logic                last_result;
	} batch_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	logic [OFF_BITS-1:0] row_offset;
	logic last_offset;
	logic empty;
	logic pop;
	logic [ROW_BITS-1:0] split_index;
	logic [OFF_BITS-1:0] element_count;
	logic size_ok;
	logic [1:0] error_code;
	logic list_done;
	logic last_result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [LIMIT_BITS-1:0] cfg_data;

	// register copies
	logic [LIMIT_BITS-1:0] cfg_limit;
	logic cfg_square;
	logic cfg_strict;
	logic cfg_absolute;

	// list state of the predictor
	logic [OFF_BITS-1:0] batch_off;
	logic [ROW_BITS-1:0] batch_row;
	logic [OFF_BITS-1:0] prev_off;
	logic [ROW_BITS-1:0] row_num;
	logic in_hold;
	logic at_start;
	logic first_batch;

	batch_result_t pending_batches[$];
	int unsigned mismatches = 0;
	int unsigned offsets_used = 0;
	int unsigned cycle_count = 0;
	int hold_cycles = 0;
	logic hold_active;
	logic send_idle = 1'b1;
	logic pop_idle = 1'b1;

	ragged_row_batch_splitter uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.row_offset(row_offset),
		.last_offset(last_offset),
		.empty(empty),
		.pop(pop),
		.split_index(split_index),
		.element_count(element_count),
		.size_ok(size_ok),
		.error_code(error_code),
		.list_done(list_done),
		.last_result(last_result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// run time guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [63:0] grow(input logic [63:0] d);
		return cfg_square ? d * d : d;
	endfunction

	function automatic void clear_list();
		batch_off = '0;
		batch_row = '0;
		prev_off = '0;
		row_num = '0;
		in_hold = 1'b0;
		at_start = 1'b1;
		first_batch = 1'b1;
	endfunction

	function automatic void reset_model();
		cfg_limit = '0;
		cfg_square = 1'b0;
		cfg_strict = 1'b0;
		cfg_absolute = 1'b0;
		clear_list();
	endfunction

	// append one expected result
	function automatic void expect_result(input batch_result_t b);
		pending_batches = {pending_batches, b};
	endfunction

	// close the open batch at row r, end offset s
	function automatic void close_at(input logic [ROW_BITS-1:0] r, input logic [OFF_BITS-1:0] s);
		batch_result_t b;
		b = '0;
		b.element_count = s - batch_off;
		b.size_ok = (b.element_count != 0) &&
			(!cfg_strict || {33'd0, b.element_count} <= {1'b0, cfg_limit});
		b.split_index = cfg_absolute ? r : r - batch_row;
		b.error_code = ERR_NONE;
		expect_result(b);
		batch_off = s;
		batch_row = r;
		first_batch = 1'b0;
	endfunction

	function automatic void flag_error(input err_t code, input logic lst);
		batch_result_t b;
		b = '0;
		b.split_index = row_num;
		b.error_code = code;
		b.list_done = lst;
		b.last_result = 1'b1;
		expect_result(b);
		if (lst) begin
			clear_list();
		end else begin
			in_hold = 1'b1;
		end
	endfunction

	function automatic void predict_offset(input logic [OFF_BITS-1:0] s, input logic lst);
		logic [63:0] lim64;
		logic [63:0] base;
		logic [63:0] d;
		logic [ROW_BITS-1:0] r;
		logic [ROW_BITS-1:0] n;
		int before_cnt;
		int last_idx;
		lim64 = {1'b0, cfg_limit};
		// inside an error hold only the end of the list matters
		if (in_hold) begin
			if (lst) clear_list();
			return;
		end
		// row zero opens the list or fails it
		if (at_start) begin
			d = grow({33'd0, s});
			if (d > lim64) begin
				flag_error(ERR_FIRST_BIG, lst);
			end else if (d == lim64 || lst) begin
				flag_error(ERR_EMPTY, lst);
			end else begin
				at_start = 1'b0;
				first_batch = 1'b1;
				batch_off = s;
				batch_row = '0;
				prev_off = s;
				row_num = ROW_BITS'(1);
			end
			return;
		end
		if (s < prev_off) begin
			flag_error(ERR_DECREASING, lst);
			return;
		end
		// greedy packing of whole rows
		before_cnt = pending_batches.size();
		r = row_num;
		base = first_batch ? 64'd0 : {33'd0, batch_off};
		d = grow({33'd0, s} - base);
		n = r - batch_row;
		if (d > lim64 && n != 1) begin
			close_at(r - ROW_BITS'(1), prev_off);
			if (grow({33'd0, s} - {33'd0, prev_off}) >= lim64 || lst) close_at(r, s);
		end else if (d == lim64 || lst || (d > lim64 && n == 1)) begin
			close_at(r, s);
		end
		prev_off = s;
		row_num = r + ROW_BITS'(1);
		if (pending_batches.size() > before_cnt) begin
			last_idx = pending_batches.size() - 1;
			pending_batches[last_idx].last_result = 1'b1;
			if (lst) pending_batches[last_idx].list_done = 1'b1;
		end
		if (lst) clear_list();
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void report(input string field, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		mismatches++;
	endfunction

	function automatic void check_batch();
		batch_result_t want;
		if (pending_batches.size() == 0) begin
			$display("%0t: unexpected result, expected none, got index %0h count %0h err %0h",
				$time, split_index, element_count, error_code);
			mismatches++;
			return;
		end
		want = pending_batches.pop_front();
		if (split_index !== want.split_index)
			report("split_index", want.split_index, split_index);
		if (element_count !== want.element_count)
			report("element_count", want.element_count, element_count);
		if (size_ok !== want.size_ok) report("size_ok", want.size_ok, size_ok);
		if (error_code !== want.error_code) report("error_code", want.error_code, error_code);
		if (list_done !== want.list_done) report("list_done", want.list_done, list_done);
		if (last_result !== want.last_result)
			report("last_result", want.last_result, last_result);
	endfunction

	// result side: random pop gaps, long hold-off on request
	initial begin : result_drain
		int wait_left;
		wait_left = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && pop === 1'b1 && empty === 1'b0) begin
				check_batch();
				wait_left = pop_idle ? $urandom_range(0, 11) : 0;
			end
			if (hold_active) begin
				pop <= 1'b0;
			end else if (wait_left > 0) begin
				pop <= 1'b0;
				wait_left--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// hold-off counter for the result side
	initial begin : hold_timer
		hold_active <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_active <= 1'b1;
				hold_cycles--;
			end else begin
				hold_active <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	// one offset transfer, then its prediction
	task automatic send_offset(input logic [OFF_BITS-1:0] off, input logic lst);
		int gap;
		gap = send_idle ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		row_offset <= off;
		last_offset <= lst;
		do @(posedge clk); while (full !== 1'b0);
		offsets_used++;
		predict_offset(off, lst);
	endtask

	// wait until every result is out and the pipeline has drained
	task automatic settle();
		push <= 1'b0;
		while (pending_batches.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [LIMIT_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_LIMIT:    cfg_limit = val;
			CFG_SQUARE:   cfg_square = val[0];
			CFG_STRICT:   cfg_strict = val[0];
			CFG_ABSOLUTE: cfg_absolute = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_mode(input logic [LIMIT_BITS-1:0] lim, input logic sq, input logic strict,
			input logic absm);
		settle();
		write_reg(CFG_LIMIT, lim);
		write_reg(CFG_SQUARE, {62'd0, sq});
		write_reg(CFG_STRICT, {62'd0, strict});
		write_reg(CFG_ABSOLUTE, {62'd0, absm});
	endtask

	function automatic logic [63:0] draw_step(input int unsigned unit);
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return unit;
			2: return unit + $urandom_range(1, unit);
			default: return $urandom_range(0, unit);
		endcase
	endfunction

	// nondecreasing list, optionally with one offset going backwards
	task automatic send_good_list(input int unsigned unit, input logic broken);
		int len;
		int bad_at;
		logic [63:0] off;
		len = $urandom_range(1, 20);
		bad_at = broken ? $urandom_range(1, len) : -1;
		off = ($urandom_range(0, 4) == 0) ? $urandom_range(0, unit) : 64'd0;
		for (int i = 0; i < len; i++) begin
			if (i > 0) begin
				if (i == bad_at && off > 0) begin
					off = $urandom_range(0, off - 1);
				end else begin
					off = off + draw_step(unit);
				end
				if (off > OFF_MAX) off = OFF_MAX;
			end
			send_offset(off[OFF_BITS-1:0], i == len - 1);
		end
	endtask

	// arbitrary offsets across the full range
	task automatic send_noise_list();
		int len;
		len = $urandom_range(1, 8);
		for (int i = 0; i < len; i++)
			send_offset(OFF_BITS'($urandom_range(0, 32'h7FFF_FFFF)), i == len - 1);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed_cases();
		send_idle = 1'b1;
		pop_idle = 1'b1;
		// zero limit: every list start fails
		set_mode(63'd0, 1'b0, 1'b0, 1'b0);
		send_offset(31'd0, 1'b1);
		send_offset(31'd3, 1'b0);
		send_offset(31'd9, 1'b0);
		send_offset(31'd1, 1'b1);
		// exact limit, oversize row alone, double close, empty last batch
		set_mode(63'd10, 1'b0, 1'b1, 1'b0);
		send_offset(31'd0, 1'b0);
		send_offset(31'd4, 1'b0);
		send_offset(31'd10, 1'b0);
		send_offset(31'd25, 1'b0);
		send_offset(31'd27, 1'b0);
		send_offset(31'd30, 1'b0);
		send_offset(31'd42, 1'b0);
		send_offset(31'd42, 1'b1);
		// list of one offset, and first offset right at the limit
		send_offset(31'd5, 1'b1);
		send_offset(31'd10, 1'b0);
		send_offset(31'd2, 1'b1);
		// decreasing offset mid list and on the last offset
		send_offset(31'd0, 1'b0);
		send_offset(31'd8, 1'b0);
		send_offset(31'd3, 1'b0);
		send_offset(31'd1, 1'b1);
		send_offset(31'd0, 1'b0);
		send_offset(31'd5, 1'b0);
		send_offset(31'd2, 1'b1);
		// largest limit and largest offsets, squared
		set_mode(63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1);
		send_offset(31'd0, 1'b0);
		send_offset(31'h7FFF_FFFF, 1'b1);
		send_offset(31'h7FFF_FFFF, 1'b0);
		send_offset(31'h7FFF_FFFF, 1'b1);
		// strict check uses the plain count in square mode
		set_mode(63'd100, 1'b1, 1'b1, 1'b0);
		send_offset(31'd0, 1'b0);
		send_offset(31'd200, 1'b0);
		send_offset(31'd205, 1'b1);
	endtask

	// result side stalls long while offsets keep coming
	task automatic test_backpressure();
		set_mode(63'd1, 1'b0, 1'b0, 1'b1);
		send_idle = 1'b0;
		pop_idle = 1'b0;
		hold_cycles = 300;
		for (int i = 0; i < 40; i++) send_offset(OFF_BITS'(i), i == 39);
	endtask

	task automatic test_random_lists();
		int unsigned unit;
		int unsigned target;
		int unsigned phase_end;
		int kind;
		logic [LIMIT_BITS-1:0] lim;
		logic sq;
		target = offsets_used + 780;
		while (offsets_used < target) begin
			kind = $urandom_range(0, 9);
			sq = 1'b0;
			if (kind <= 3) begin
				unit = $urandom_range(1, 200);
				lim = unit;
			end else if (kind <= 6) begin
				sq = 1'b1;
				unit = $urandom_range(1, 60);
				lim = unit * unit + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 2 * unit));
			end else if (kind == 7) begin
				unit = $urandom_range(1 << 20, 1 << 30);
				lim = unit;
			end else if (kind == 8) begin
				sq = $urandom_range(0, 1);
				unit = 1 << 30;
				lim = $urandom_range(0, 1) ? {LIMIT_BITS{1'b1}} : {$urandom, $urandom} >> 1;
			end else begin
				sq = $urandom_range(0, 1);
				unit = 2;
				lim = $urandom_range(0, 2);
			end
			set_mode(lim, sq, $urandom_range(0, 1), $urandom_range(0, 1));
			send_idle = ($urandom_range(0, 3) != 0);
			pop_idle = ($urandom_range(0, 3) != 0);
			phase_end = offsets_used + 70;
			while (offsets_used < phase_end) begin
				case ($urandom_range(0, 9))
					0: send_noise_list();
					1: send_good_list(unit, 1'b1);
					default: send_good_list(unit, 1'b0);
				endcase
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		row_offset <= '0;
		last_offset <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_LIMIT;
		cfg_data <= '0;
		reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_backpressure();
		test_random_lists();
		settle();
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
